// ----- hdl/fbfla_pkg.sv -----
// ----------------------------------------------------------------------------
// fbfla_pkg
// Types, constants and helpers shared by the fixed-block free-list allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

	localparam int NUM_BLOCKS = 32;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int LINK_W     = IDX_W + 1;
	localparam int COUNT_W    = 6;

	localparam logic [LINK_W-1:0]  LINK_NULL   = LINK_W'(NUM_BLOCKS);
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(32);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic {
		ST_OK    = 1'b0,
		ST_EMPTY = 1'b1
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	typedef struct packed {
		op_t              operation;
		logic [IDX_W-1:0] block_index;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] result_index;
		status_t          status;
	} out_item_t;

	// result handed from the list engine to the output queue
	typedef struct packed {
		logic      valid;
		out_item_t item;
	} res_push_t;

	// block_count of 0 counts as 1, anything above the pool size as the pool size
	function automatic logic [LINK_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
		logic [LINK_W-1:0] r;
		if (v == '0) begin
			r = LINK_W'(1);
		end else if (v > COUNT_W'(NUM_BLOCKS)) begin
			r = LINK_NULL;
		end else begin
			r = LINK_W'(v);
		end
		return r;
	endfunction

	// link an entry holds after initialization: the next block, or null at the end
	function automatic logic [LINK_W-1:0] init_link(input logic [IDX_W-1:0] idx,
		input logic [LINK_W-1:0] count);
		logic [LINK_W-1:0] nxt;
		nxt = {1'b0, idx} + LINK_W'(1);
		return (nxt < count) ? nxt : LINK_NULL;
	endfunction

endpackage

// ----- hdl/fbfla_ram.sv -----
// ----------------------------------------------------------------------------
// fbfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbfla_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/fbfla_list.sv -----
// ----------------------------------------------------------------------------
// fbfla_list
// Free-list engine: head register, link RAM with per-entry valid bits, and
// the sequencer that pops on allocate and pushes on free.
// ----------------------------------------------------------------------------
module fbfla_list (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  fbfla_pkg::in_item_t                  in_item,
	input  logic                                 space,
	output fbfla_pkg::res_push_t                 res_push,
	input  logic                                 cfg_we,
	input  logic [fbfla_pkg::COUNT_W-1:0]        cfg_wdata
);

	fbfla_pkg::state_t                  state_q, state_d;
	logic [fbfla_pkg::LINK_W-1:0]       head_q, head_d;
	logic [fbfla_pkg::LINK_W-1:0]       count_q;
	logic [fbfla_pkg::NUM_BLOCKS-1:0]   link_valid_q;

	// allocate in flight
	logic [fbfla_pkg::IDX_W-1:0]        got_s1;
	logic                               valid_s1;
	logic [fbfla_pkg::LINK_W-1:0]       dflt_s1;

	logic                               accept;
	logic                               head_empty;
	logic                               ram_we, ram_re;
	logic [fbfla_pkg::LINK_W-1:0]       ram_rdata;

	assign head_empty = (head_q >= fbfla_pkg::LINK_NULL);
	assign in_ready   = (state_q == fbfla_pkg::S_IDLE) && space;
	assign accept     = in_valid && in_ready;

	fbfla_ram #(
		.WIDTH(fbfla_pkg::LINK_W),
		.DEPTH(fbfla_pkg::NUM_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_item.block_index),
		.wdata (head_q),
		.re    (ram_re),
		.raddr (head_q[fbfla_pkg::IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		res_push = '0;
		case (state_q)
			fbfla_pkg::S_IDLE: begin
				if (accept) begin
					if (in_item.operation == fbfla_pkg::OP_FREE) begin
						ram_we                     = 1'b1;
						head_d                     = {1'b0, in_item.block_index};
						res_push.valid             = 1'b1;
						res_push.item.result_index = in_item.block_index;
						res_push.item.status       = fbfla_pkg::ST_OK;
					end else if (head_empty) begin
						res_push.valid             = 1'b1;
						res_push.item.result_index = '0;
						res_push.item.status       = fbfla_pkg::ST_EMPTY;
					end else begin
						ram_re  = 1'b1;
						state_d = fbfla_pkg::S_READ;
					end
				end
			end
			fbfla_pkg::S_READ: begin
				// a link never written since init reads as its init value
				head_d                     = valid_s1 ? ram_rdata : dflt_s1;
				res_push.valid             = 1'b1;
				res_push.item.result_index = got_s1;
				res_push.item.status       = fbfla_pkg::ST_OK;
				state_d                    = fbfla_pkg::S_IDLE;
			end
			default: begin
				state_d = fbfla_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fbfla_pkg::S_IDLE;
			head_q       <= '0;
			count_q      <= fbfla_pkg::clamp_count(fbfla_pkg::COUNT_RESET);
			link_valid_q <= '0;
		end else if (cfg_we) begin
			state_q      <= fbfla_pkg::S_IDLE;
			head_q       <= '0;
			count_q      <= fbfla_pkg::clamp_count(cfg_wdata);
			link_valid_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			if (ram_we) begin
				link_valid_q[in_item.block_index] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			got_s1   <= head_q[fbfla_pkg::IDX_W-1:0];
			valid_s1 <= link_valid_q[head_q[fbfla_pkg::IDX_W-1:0]];
			dflt_s1  <= fbfla_pkg::init_link(head_q[fbfla_pkg::IDX_W-1:0], count_q);
		end
	end

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fbfla_pkg::S_READ |=> state_q == fbfla_pkg::S_IDLE)
		else $error("allocate read held longer than one cycle");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= fbfla_pkg::LINK_NULL)
		else $error("head beyond null code");

	a_no_accept_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fbfla_pkg::S_READ |-> !in_ready && res_push.valid)
		else $error("input taken or result missing during allocate read");

endmodule

// ----- hdl/fbfla_obuf.sv -----
// ----------------------------------------------------------------------------
// fbfla_obuf
// Two-entry output queue: output register plus skid slot.
// ----------------------------------------------------------------------------
module fbfla_obuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fbfla_pkg::res_push_t  res_push,
	output logic                  space,
	output logic                  out_valid,
	input  logic                  out_ready,
	output fbfla_pkg::out_item_t  out_item
);

	logic [1:0]           count_q;
	fbfla_pkg::out_item_t out_q, skid_q;
	logic                 pop;

	assign out_valid = (count_q != 2'd0);
	assign out_item  = out_q;
	assign pop       = out_valid && out_ready;
	// room for one more result, counting the one an accepted item may yet produce
	assign space     = (count_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + 2'(res_push.valid) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		case ({res_push.valid, pop})
			2'b10: begin
				if (count_q == 2'd0) begin
					out_q <= res_push.item;
				end else begin
					skid_q <= res_push.item;
				end
			end
			2'b01: begin
				out_q <= skid_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					out_q <= res_push.item;
				end else begin
					out_q  <= skid_q;
					skid_q <= res_push.item;
				end
			end
			default: begin
			end
		endcase
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("output queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push.valid && count_q == 2'd2 |-> pop)
		else $error("result pushed into full output queue");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result beat dropped or changed while stalled");

endmodule

// ----- hdl/fixed_block_free_list_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit
// LIFO free-list allocator for a pool of equal-size blocks.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------
//   in       | in  | in_valid / in_ready  | in_item  (operation, block_index)
//   out      | out | out_valid / out_ready| out_item (result_index, status)
//   cfg      | in  | cfg_we               | cfg_wdata (block_count)
//
// Free and allocate-on-empty hand their result to the output queue in the cycle
// they are accepted; allocate first waits in S_READ for the registered read data of the link RAM.
// Reset and a block_count write rebuild the list by clearing the per-entry
// valid bits, so unwritten links read as their initial value.
// Up to two results are held; the input stalls while both slots are taken.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  fbfla_pkg::in_item_t           in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output fbfla_pkg::out_item_t          out_item,
	input  logic                          cfg_we,
	input  logic [fbfla_pkg::COUNT_W-1:0] cfg_wdata
);

	fbfla_pkg::res_push_t res_push;
	logic                 space;

	fbfla_list u_list (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.space     (space),
		.res_push  (res_push),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	fbfla_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ----- bench/fixed_block_free_list_allocator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit_tb
// Self-checking bench for the LIFO free-list block allocator. A driver feeds
// allocate/free requests from a queue and a monitor checks each result beat
// against a predicted pool. The bench runs several block_count settings with
// random idle bursts on both sides, and a closing stretch without them.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int CFG_SETTLE  = 8;
	localparam int MIX_ITEMS   = 62;

	typedef struct packed {
		logic [fbfla_pkg::NUM_BLOCKS-1:0][fbfla_pkg::LINK_W-1:0] link;
		logic [fbfla_pkg::LINK_W-1:0]                            head;
		logic [fbfla_pkg::LINK_W-1:0]                            count;
	} pool_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	fbfla_pkg::in_item_t  in_item = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	fbfla_pkg::out_item_t out_item;
	logic                 cfg_we = 1'b0;
	logic [fbfla_pkg::COUNT_W-1:0] cfg_wdata = '0;

	// pool as seen by the request generator, and as seen at accept time
	pool_t                gen_pool;
	pool_t                chk_pool;
	fbfla_pkg::in_item_t  pending_requests[$];
	fbfla_pkg::out_item_t expected_results[$];
	logic [fbfla_pkg::IDX_W-1:0] held_blocks[$];

	logic      bursty = 1'b1;
	int        in_gap = 0;
	int        out_gap = 0;
	int        quiet_cycles = 0;
	int        mismatches = 0;
	int        n_alloc = 0;
	int        n_free = 0;
	int        n_empty = 0;
	int        n_settings = 0;

	always #5 clk = ~clk;

	fixed_block_free_list_allocator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// rebuild the list: block i links to i+1, the last block of the pool to null
	function automatic pool_t fresh_pool(input logic [fbfla_pkg::COUNT_W-1:0] raw);
		pool_t p;
		logic [fbfla_pkg::LINK_W-1:0] cnt;
		if (raw == '0) begin
			cnt = fbfla_pkg::LINK_W'(1);
		end else if (raw > fbfla_pkg::COUNT_W'(fbfla_pkg::NUM_BLOCKS)) begin
			cnt = fbfla_pkg::LINK_W'(fbfla_pkg::NUM_BLOCKS);
		end else begin
			cnt = fbfla_pkg::LINK_W'(raw);
		end
		for (int i = 0; i < fbfla_pkg::NUM_BLOCKS; i++) begin
			p.link[i] = (fbfla_pkg::LINK_W'(i + 1) < cnt) ?
				fbfla_pkg::LINK_W'(i + 1) : fbfla_pkg::LINK_NULL;
		end
		p.head = '0;
		p.count = cnt;
		return p;
	endfunction

	// pop the head on allocate, push the index on free
	function automatic fbfla_pkg::out_item_t pool_step(inout pool_t p,
		input fbfla_pkg::in_item_t req);
		fbfla_pkg::out_item_t r;
		r.result_index = req.block_index;
		r.status = fbfla_pkg::ST_OK;
		if (req.operation == fbfla_pkg::OP_ALLOC) begin
			if (p.head >= fbfla_pkg::LINK_W'(fbfla_pkg::NUM_BLOCKS)) begin
				r.result_index = '0;
				r.status = fbfla_pkg::ST_EMPTY;
			end else begin
				r.result_index = p.head[fbfla_pkg::IDX_W-1:0];
				p.head = p.link[p.head[fbfla_pkg::IDX_W-1:0]];
			end
		end else begin
			p.link[req.block_index] = p.head;
			p.head = {1'b0, req.block_index};
		end
		return r;
	endfunction

	task automatic queue_request(input fbfla_pkg::op_t op,
		input logic [fbfla_pkg::IDX_W-1:0] idx);
		fbfla_pkg::in_item_t req;
		fbfla_pkg::out_item_t r;
		req.operation = op;
		req.block_index = idx;
		r = pool_step(gen_pool, req);
		if (op == fbfla_pkg::OP_ALLOC && r.status == fbfla_pkg::ST_OK) begin
			held_blocks.push_back(r.result_index);
		end
		pending_requests.push_back(req);
	endtask

	task automatic free_held();
		int k;
		k = $urandom_range(0, held_blocks.size() - 1);
		queue_request(fbfla_pkg::OP_FREE, held_blocks[k]);
		held_blocks.delete(k);
	endtask

	task automatic drain();
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (CFG_SETTLE) @(posedge clk);
	endtask

	task automatic write_count(input logic [fbfla_pkg::COUNT_W-1:0] value);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_pool = fresh_pool(value);
		chk_pool = fresh_pool(value);
		held_blocks.delete();
		n_settings++;
	endtask

	// mostly balanced alloc/free of owned blocks, with stray frees mixed in
	task automatic run_mix(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				queue_request(fbfla_pkg::OP_FREE,
					fbfla_pkg::IDX_W'($urandom_range(0, fbfla_pkg::NUM_BLOCKS - 1)));
			end else if (r < 55 && held_blocks.size() != 0) begin
				free_held();
			end else begin
				queue_request(fbfla_pkg::OP_ALLOC,
					fbfla_pkg::IDX_W'($urandom_range(0, fbfla_pkg::NUM_BLOCKS - 1)));
			end
		end
	endtask

	// driver: hold the beat until accepted, then advance or idle
	always @(posedge clk or negedge arst_n) begin
		logic nxt_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(pool_step(chk_pool, in_item));
				if (in_item.operation == fbfla_pkg::OP_ALLOC) begin
					n_alloc++;
				end else begin
					n_free++;
				end
			end
			if (!(in_valid && !in_ready)) begin
				nxt_valid = 1'b0;
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_requests.size() != 0) begin
					if (bursty && $urandom_range(0, 7) == 0) begin
						in_gap = $urandom_range(0, 15);
					end else begin
						in_item <= pending_requests.pop_front();
						nxt_valid = 1'b1;
					end
				end
				in_valid <= nxt_valid;
			end
		end
	end

	// monitor: check result beats and throttle out_ready
	always @(posedge clk or negedge arst_n) begin
		fbfla_pkg::out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result beat: index %0d status %0d",
							out_item.result_index, out_item.status);
					end
				end else begin
					want = expected_results.pop_front();
					if (out_item.status == fbfla_pkg::ST_EMPTY) begin
						n_empty++;
					end
					if (out_item.result_index != want.result_index
						|| out_item.status != want.status) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: want idx %0d st %0d, got idx %0d st %0d",
								want.result_index, want.status,
								out_item.result_index, out_item.status);
						end
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (bursty && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		gen_pool = fresh_pool(fbfla_pkg::COUNT_RESET);
		chk_pool = fresh_pool(fbfla_pkg::COUNT_RESET);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// full pool out of reset: pops, a double free of a free block, pushes
		queue_request(fbfla_pkg::OP_ALLOC, 5'd31);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		queue_request(fbfla_pkg::OP_FREE, 5'd31);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		queue_request(fbfla_pkg::OP_FREE, 5'd1);
		queue_request(fbfla_pkg::OP_FREE, 5'd0);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);

		// one block: empty pool, free of an index beyond the pool
		write_count(6'd1);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd31);
		queue_request(fbfla_pkg::OP_FREE, 5'd20);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);

		// zero clamps to one block, all ones clamps to the full pool
		write_count(6'd0);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		write_count(6'd63);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		queue_request(fbfla_pkg::OP_FREE, 5'd31);
		queue_request(fbfla_pkg::OP_FREE, 5'd31);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);
		queue_request(fbfla_pkg::OP_ALLOC, 5'd0);

		run_mix(MIX_ITEMS);
		write_count(6'd2);
		run_mix(MIX_ITEMS);
		write_count(6'd1);
		run_mix(MIX_ITEMS);
		write_count(fbfla_pkg::COUNT_W'($urandom_range(1, fbfla_pkg::NUM_BLOCKS)));
		run_mix(MIX_ITEMS);
		write_count(fbfla_pkg::COUNT_W'($urandom_range(1, fbfla_pkg::NUM_BLOCKS)));
		run_mix(MIX_ITEMS);
		write_count(6'd33);
		run_mix(MIX_ITEMS);
		write_count(fbfla_pkg::COUNT_W'($urandom_range(1, 4)));
		run_mix(MIX_ITEMS);

		// closing stretch at full rate
		write_count(6'd32);
		bursty = 1'b0;
		run_mix(MIX_ITEMS);

		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d allocates (%0d on an empty pool) and %0d frees",
			n_alloc, n_empty, n_free);
		$display("across %0d block_count writes; %0d mismatches", n_settings, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
